/* rtl/core/tmdf_pkg.sv */
// ---------------------------------------------------------------------------
// tmdf_pkg
// Shared types and codes for the timed message delay FIFO.
// ---------------------------------------------------------------------------
`default_nettype none

package tmdf_pkg;

    // operation codes carried in s_tuser
    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    // result codes carried in m_tuser
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    localparam logic [15:0] DELAY_RESET = 16'd500;
    localparam logic [7:0]  MAX_LENGTH  = 8'd255;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the accepted item
        logic commit;    // execute the item and load the output register
    } tmdf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a new result this cycle
    } tmdf_stat_t;

endpackage

`default_nettype wire

/* rtl/core/timed_message_delay_fifo.sv */
// Items are taken one at a time: accept, registered read of the byte store and message
//   table at the head pointers, then execute and load the output register. Execute waits
//   while the output register is full and m_tready is low; a new item is accepted only after.
// Reset: aresetn is synchronous, active low; pointers, counts and the open-message state
//   clear, release_delay returns to 500. Byte store and message table are not cleared.
// ---------------------------------------------------------------------------
// timed_message_delay_fifo
// FIFO of byte messages, each held until its arrival time plus release_delay.
// ---------------------------------------------------------------------------
`default_nettype none

module timed_message_delay_fifo
    import tmdf_pkg::*;
#(
    parameter int STORE_BYTES  = 4096,
    parameter int MAX_MESSAGES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,    // now_time[31:0], data_byte[39:32]
    input  wire logic        s_tlast,    // last_byte
    input  wire logic [1:0]  s_tuser,    // func
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // out_byte[7:0], out_length[15:8]
    output logic             m_tlast,    // out_last
    output logic [1:0]       m_tuser,    // status
    // release_delay register
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    tmdf_cmd_t  cmd;
    tmdf_stat_t stat;

    // sequencer: one item in flight at a time
    tmdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // queue state, memories and output register
    tmdf_dpath #(
        .STORE_BYTES  (STORE_BYTES),
        .MAX_MESSAGES (MAX_MESSAGES)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_func     (s_tuser),
        .in_now      (s_tdata[31:0]),
        .in_byte     (s_tdata[39:32]),
        .in_last     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

`ifndef SYNTHESIS
    // an item is never taken while another executes
    a_no_accept_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> !cmd.commit)
        else $error("item accepted during execute");

    // memory read cycle always separates capture and execute
    a_read_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !cmd.commit)
        else $error("execute without memory read cycle");

    // every execute presents a result
    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("result lost after execute");
`endif

endmodule

`default_nettype wire

/* rtl/core/tmdf_ctrl.sv */
// ---------------------------------------------------------------------------
// tmdf_ctrl
// Sequencer: accept, read memories, execute once the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module tmdf_ctrl
    import tmdf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire tmdf_stat_t stat,
    output tmdf_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    assign s_tready    = ready_reg;
    assign cmd.capture = s_tvalid && ready_reg;
    assign cmd.commit  = (state_reg == ST_EXEC) && stat.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    ready_reg <= 1'b1;
                    if (s_tvalid && ready_reg) begin
                        state_reg <= ST_READ;
                        ready_reg <= 1'b0;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (stat.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tmdf_dpath.sv */
// ---------------------------------------------------------------------------
// tmdf_dpath
// Queue state, byte store, message table and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tmdf_dpath
    import tmdf_pkg::*;
#(
    parameter int STORE_BYTES  = 4096,
    parameter int MAX_MESSAGES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire tmdf_cmd_t   cmd,
    output tmdf_stat_t       stat,
    input  wire logic [1:0]  in_func,
    input  wire logic [31:0] in_now,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast,
    output logic [1:0]       m_tuser
);

    localparam int SA  = $clog2(STORE_BYTES);
    localparam int SCW = $clog2(STORE_BYTES + 1);
    localparam int EA  = $clog2(MAX_MESSAGES);
    localparam int ECW = $clog2(MAX_MESSAGES + 1);
    localparam int SLAST = STORE_BYTES - 1;
    localparam int ELAST = MAX_MESSAGES - 1;

    localparam logic [SA:0]    STORE_N   = STORE_BYTES[SA:0];
    localparam logic [SCW:0]   STORE_CAP = STORE_BYTES[SCW:0];
    localparam logic [SA-1:0]  STORE_END = SLAST[SA-1:0];
    localparam logic [EA-1:0]  ENT_END   = ELAST[EA-1:0];
    localparam logic [ECW-1:0] ENT_CAP   = MAX_MESSAGES[ECW-1:0];

    // memories
    logic [7:0]  byte_mem [STORE_BYTES];
    logic [7:0]  len_mem  [MAX_MESSAGES];
    logic [31:0] rel_mem  [MAX_MESSAGES];
    logic [7:0]  byte_rd_reg;
    logic [7:0]  len_rd_reg;
    logic [31:0] rel_rd_reg;

    // item
    logic [1:0]  func_reg;
    logic [31:0] now_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    logic [15:0] delay_reg;

    // queue state
    logic [EA-1:0]  ent_head_reg, ent_head_next;
    logic [EA-1:0]  ent_tail_reg, ent_tail_next;
    logic [ECW-1:0] ent_count_reg, ent_count_next;
    logic [SA-1:0]  st_head_reg, st_head_next;
    logic [SA-1:0]  st_tail_reg, st_tail_next;
    logic [SCW-1:0] st_count_reg, st_count_next;
    logic           open_reg, open_next;
    logic [7:0]     plen_reg, plen_next;
    logic [31:0]    prel_reg, prel_next;
    logic [7:0]     poff_reg, poff_next;
    logic           drop_reg, drop_next;

    // output register
    logic        ovalid_reg;
    logic [1:0]  ostatus_reg, ostatus_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;
    logic [7:0]  olen_reg, olen_next;

    // combinational helpers
    logic [7:0]   open_len;
    logic [7:0]   new_len;
    logic [31:0]  open_rel;
    logic [SCW:0] room_sum;
    logic [SA:0]  wr_sum, wr_wrap;
    logic [SA:0]  tl_sum, tl_wrap;
    logic [SA-1:0] wr_addr;
    logic         push_fail;
    logic         byte_we, ent_we;
    logic [31:0]  rel_diff;
    logic [8:0]   off_inc;
    logic         msg_end;

    assign stat.out_free = !ovalid_reg || m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {olen_reg, obyte_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = ostatus_reg;

    always_comb begin
        open_len  = open_reg ? plen_reg : 8'd0;
        new_len   = open_len + 8'd1;
        open_rel  = open_reg ? prel_reg : (now_reg + {16'd0, delay_reg});
        room_sum  = (SCW + 1)'(st_count_reg) + (SCW + 1)'(open_len);
        wr_sum    = (SA + 1)'(st_tail_reg) + (SA + 1)'(open_len);
        wr_wrap   = wr_sum - STORE_N;
        wr_addr   = (wr_sum >= STORE_N) ? wr_wrap[SA-1:0] : wr_sum[SA-1:0];
        tl_sum    = (SA + 1)'(st_tail_reg) + (SA + 1)'(new_len);
        tl_wrap   = tl_sum - STORE_N;
        push_fail = (open_len == MAX_LENGTH) || (room_sum >= STORE_CAP) ||
                    (last_reg && (ent_count_reg >= ENT_CAP));
        rel_diff  = rel_rd_reg - now_reg;
        off_inc   = {1'b0, poff_reg} + 9'd1;
        msg_end   = off_inc >= {1'b0, len_rd_reg};

        ent_head_next  = ent_head_reg;
        ent_tail_next  = ent_tail_reg;
        ent_count_next = ent_count_reg;
        st_head_next   = st_head_reg;
        st_tail_next   = st_tail_reg;
        st_count_next  = st_count_reg;
        open_next      = open_reg;
        plen_next      = plen_reg;
        prel_next      = prel_reg;
        poff_next      = poff_reg;
        drop_next      = drop_reg;
        ostatus_next   = STATUS_OK;
        obyte_next     = 8'd0;
        olast_next     = 1'b0;
        olen_next      = 8'd0;
        byte_we        = 1'b0;
        ent_we         = 1'b0;

        case (func_reg)
            FUNC_PUSH: begin
                if (drop_reg) begin
                    // discard the tail of a dropped message
                    ostatus_next = STATUS_DROPPED;
                    if (last_reg) begin
                        drop_next = 1'b0;
                    end
                end else if (push_fail) begin
                    ostatus_next = STATUS_DROPPED;
                    open_next    = 1'b0;
                    plen_next    = 8'd0;
                    prel_next    = open_rel;
                    drop_next    = !last_reg;
                end else begin
                    byte_we = 1'b1;
                    if (last_reg) begin
                        ent_we         = 1'b1;
                        ent_tail_next  = (ent_tail_reg == ENT_END) ? '0 : ent_tail_reg + 1'b1;
                        ent_count_next = ent_count_reg + 1'b1;
                        st_tail_next   = (tl_sum >= STORE_N) ? tl_wrap[SA-1:0]
                                                             : tl_sum[SA-1:0];
                        st_count_next  = st_count_reg + SCW'(new_len);
                        open_next      = 1'b0;
                        plen_next      = 8'd0;
                        prel_next      = open_rel;
                    end else begin
                        open_next = 1'b1;
                        plen_next = new_len;
                        prel_next = open_rel;
                    end
                end
            end
            FUNC_POP: begin
                if (ent_count_reg == '0) begin
                    ostatus_next = STATUS_EMPTY;
                end else if ((poff_reg == 8'd0) && !rel_diff[31]) begin
                    // head message not yet due
                    ostatus_next = STATUS_EMPTY;
                end else begin
                    obyte_next   = byte_rd_reg;
                    olen_next    = len_rd_reg;
                    st_head_next = (st_head_reg == STORE_END) ? '0 : st_head_reg + 1'b1;
                    if (st_count_reg != '0) begin
                        st_count_next = st_count_reg - 1'b1;
                    end
                    if (msg_end) begin
                        olast_next     = 1'b1;
                        poff_next      = 8'd0;
                        ent_head_next  = (ent_head_reg == ENT_END) ? '0 : ent_head_reg + 1'b1;
                        ent_count_next = ent_count_reg - 1'b1;
                    end else begin
                        poff_next = off_inc[7:0];
                    end
                end
            end
            FUNC_FLUSH: begin
                ent_head_next  = '0;
                ent_tail_next  = '0;
                ent_count_next = '0;
                st_head_next   = '0;
                st_tail_next   = '0;
                st_count_next  = '0;
                open_next      = 1'b0;
                plen_next      = 8'd0;
                prel_next      = 32'd0;
                poff_next      = 8'd0;
                drop_next      = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // memories: written on commit, read every cycle at the head pointers
    always_ff @(posedge aclk) begin
        if (cmd.commit && byte_we) begin
            byte_mem[wr_addr] <= byte_reg;
        end
        if (cmd.commit && ent_we) begin
            len_mem[ent_tail_reg] <= new_len;
            rel_mem[ent_tail_reg] <= open_rel;
        end
        byte_rd_reg <= byte_mem[st_head_reg];
        len_rd_reg  <= len_mem[ent_head_reg];
        rel_rd_reg  <= rel_mem[ent_head_reg];
    end

    // item and output payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= in_func;
            now_reg  <= in_now;
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (cmd.commit) begin
            ostatus_reg <= ostatus_next;
            obyte_reg   <= obyte_next;
            olast_reg   <= olast_next;
            olen_reg    <= olen_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg     <= DELAY_RESET;
            ent_head_reg  <= '0;
            ent_tail_reg  <= '0;
            ent_count_reg <= '0;
            st_head_reg   <= '0;
            st_tail_reg   <= '0;
            st_count_reg  <= '0;
            open_reg      <= 1'b0;
            plen_reg      <= 8'd0;
            prel_reg      <= 32'd0;
            poff_reg      <= 8'd0;
            drop_reg      <= 1'b0;
            ovalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                delay_reg <= cfg_wr_data;
            end
            if (cmd.commit) begin
                ent_head_reg  <= ent_head_next;
                ent_tail_reg  <= ent_tail_next;
                ent_count_reg <= ent_count_next;
                st_head_reg   <= st_head_next;
                st_tail_reg   <= st_tail_next;
                st_count_reg  <= st_count_next;
                open_reg      <= open_next;
                plen_reg      <= plen_next;
                prel_reg      <= prel_next;
                poff_reg      <= poff_next;
                drop_reg      <= drop_next;
                ovalid_reg    <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* dv/timed_message_delay_fifo_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// timed_message_delay_fifo_tb
// Self-checking bench for the timed message delay FIFO. A directed table
// covers the release-time edges, the wrap-safe compare, flush and the unused
// op. Loops fill the length and table limits. Random traffic then runs
// under several release delays and back-pressure mixes. Every result item is
// checked field by field against its typed row or an in-bench model of the queue.
// ---------------------------------------------------------------------------

module timed_message_delay_fifo_tb;
    import tmdf_pkg::*;

    localparam int STORE_BYTES  = 4096;
    localparam int MAX_MESSAGES = 64;
    localparam int SA_W         = $clog2(STORE_BYTES);
    localparam int EA_W         = $clog2(MAX_MESSAGES);

    localparam logic [1:0] FUNC_UNUSED = 2'd3;  // no-op code, not in the package

    localparam int LONG_HOLD    = 400;          // receiver stall, in cycles
    localparam int PHASE_ITEMS  = 190;          // counted random items per phase
    localparam int DRAIN_CYCLES = 6;            // well past the block latency

    // one result item, as the block reports it
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_byte;
        logic       out_last;
        logic [7:0] out_length;
    } delay_result_t;

    localparam delay_result_t RES_OK_ZERO = '{STATUS_OK, 8'h00, 1'b0, 8'h00};
    localparam delay_result_t RES_EMPTY   = '{STATUS_EMPTY, 8'h00, 1'b0, 8'h00};

    // directed row; typed rows carry their result, the rest use the model
    typedef struct packed {
        logic [1:0]    fn;
        logic [31:0]   now;
        logic [7:0]    dbyte;
        logic          last_b;
        logic          typed;
        delay_result_t res;
    } dir_row_t;

    localparam int N_DIR = 23;

    // ---------------------------------------------------------------------
    // clock, reset, DUT
    // ---------------------------------------------------------------------
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata     = '0;   // now_time[31:0], data_byte[39:32]
    logic        s_tlast     = 1'b0; // last_byte
    logic [1:0]  s_tuser     = '0;   // func
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;            // out_byte[7:0], out_length[15:8]
    logic        m_tlast;            // out_last
    logic [1:0]  m_tuser;            // status
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    always #6 aclk = ~aclk;

    timed_message_delay_fifo #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_MESSAGES(MAX_MESSAGES)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // ---------------------------------------------------------------------
    // queue model: byte ring, message table, open-message and pop state
    // ---------------------------------------------------------------------
    logic [7:0]      held_bytes  [STORE_BYTES];
    logic [7:0]      msg_len     [MAX_MESSAGES];
    logic [31:0]     msg_release [MAX_MESSAGES];
    logic [EA_W-1:0] msg_head, msg_tail;
    logic [EA_W:0]   msg_count;
    logic [SA_W-1:0] byte_head, byte_tail;
    logic [SA_W:0]   byte_count;
    logic            open_msg, dropping;
    logic [7:0]      open_len, pop_pos;
    logic [31:0]     open_release;
    logic [15:0]     delay_ticks;

    delay_result_t   awaited_results [$];

    int   mismatch_count = 0;
    int   items_total    = 0;
    int   items_random   = 0;
    int   bytes_out      = 0;
    int   not_ready_seen = 0;
    int   drops_seen     = 0;
    int   src_idle_pct   = 32;
    int   sink_idle_pct  = 84;
    int   hold_orders    = 0;   // bumped by the stimulus to ask for a long stall
    int   hold_seen      = 0;
    int   hold_left      = 0;
    logic [31:0] tick;

    dir_row_t dir_rows [N_DIR];

    function automatic void clear_queue_model();
        msg_head     = '0;
        msg_tail     = '0;
        msg_count    = '0;
        byte_head    = '0;
        byte_tail    = '0;
        byte_count   = '0;
        open_msg     = 1'b0;
        dropping     = 1'b0;
        open_len     = '0;
        open_release = '0;
        pop_pos      = '0;
    endfunction

    // one item through the model; returns the result it must produce
    function automatic delay_result_t delay_fifo_step(input logic [1:0] fn,
                                                      input logic [31:0] now,
                                                      input logic [7:0] dbyte,
                                                      input logic last_b);
        delay_result_t r;
        logic [31:0]   gap;
        logic [7:0]    len;
        r = RES_OK_ZERO;
        case (fn)
            FUNC_PUSH: begin
                if (dropping) begin
                    // rest of a dropped message is swallowed up to its last byte
                    if (last_b) dropping = 1'b0;
                    r.status = STATUS_DROPPED;
                end else begin
                    if (!open_msg) begin
                        open_msg     = 1'b1;
                        open_len     = '0;
                        open_release = now + 32'(delay_ticks);
                    end
                    if (open_len >= MAX_LENGTH ||
                        int'(byte_count) + int'(open_len) >= STORE_BYTES ||
                        (last_b && int'(msg_count) >= MAX_MESSAGES)) begin
                        open_msg = 1'b0;
                        open_len = '0;
                        dropping = !last_b;
                        r.status = STATUS_DROPPED;
                    end else begin
                        held_bytes[SA_W'(byte_tail + open_len)] = dbyte;
                        open_len = open_len + 8'd1;
                        if (last_b) begin
                            msg_len[msg_tail]     = open_len;
                            msg_release[msg_tail] = open_release;
                            msg_tail   = msg_tail + 1'b1;
                            msg_count  = msg_count + 1'b1;
                            byte_tail  = byte_tail + SA_W'(open_len);
                            byte_count = byte_count + (SA_W + 1)'(open_len);
                            open_msg   = 1'b0;
                            open_len   = '0;
                        end
                    end
                end
            end
            FUNC_POP: begin
                gap = msg_release[msg_head] - now;
                if (msg_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else if (pop_pos == 0 && !gap[31]) begin
                    // head not released yet: signed (release - now) not negative
                    r.status = STATUS_EMPTY;
                end else begin
                    len          = msg_len[msg_head];
                    r.out_byte   = held_bytes[byte_head];
                    r.out_length = len;
                    byte_head    = byte_head + 1'b1;
                    if (byte_count > 0) byte_count = byte_count - 1'b1;
                    pop_pos = pop_pos + 8'd1;
                    if (pop_pos >= len) begin
                        r.out_last = 1'b1;
                        pop_pos    = '0;
                        msg_head   = msg_head + 1'b1;
                        msg_count  = msg_count - 1'b1;
                    end
                end
            end
            FUNC_FLUSH: clear_queue_model();
            default: ;  // unused code: no change
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------------
    task automatic send_item(input logic [1:0] fn, input logic [31:0] now,
                             input logic [7:0] dbyte, input logic last_b,
                             input logic typed = 1'b0,
                             input delay_result_t typed_res = '0);
        delay_result_t pred;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {dbyte, now};
        s_tlast  <= last_b;
        do @(posedge aclk); while (!s_tready);
        // accepted at this edge
        pred = delay_fifo_step(fn, now, dbyte, last_b);
        awaited_results.push_back(typed ? typed_res : pred);
        items_total++;
    endtask

    task automatic push_bytes(input int n, input logic close);
        for (int i = 0; i < n; i++) begin
            send_item(FUNC_PUSH, tick, 8'($urandom), close && (i == n - 1));
            tick = tick + 32'd1;
        end
    endtask

    task automatic pop_burst(input int n);
        for (int i = 0; i < n; i++)
            send_item(FUNC_POP, tick, 8'($urandom), 1'($urandom));
    endtask

    // hold the sender until every awaited result item has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
    endtask

    task automatic write_release_delay(input logic [15:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        delay_ticks = value;
    endtask

    // mostly well-formed messages and pops, with flushes, no-ops and noise
    task automatic random_traffic(input int target);
        int          done;
        int          r;
        int          n;
        logic [1:0]  fn;
        done = 0;
        while (done < target) begin
            r = $urandom_range(99);
            if (r < 50) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(4) == 0) begin
                        pop_burst(1);
                        done++;
                    end
                    send_item(FUNC_PUSH, tick, 8'($urandom), i == n - 1);
                    tick = tick + 32'($urandom_range(0, 3));
                    done++;
                end
            end else if (r < 88) begin
                // sometimes let time run past the current delay
                if ($urandom_range(2) == 0)
                    tick = tick + 32'($urandom_range(0, int'(delay_ticks) * 3 / 2 + 2));
                n = $urandom_range(1, 5);
                pop_burst(n);
                done += n;
            end else if (r < 91) begin
                send_item(FUNC_FLUSH, tick, 8'($urandom), 1'($urandom));
                done++;
            end else if (r < 95) begin
                send_item(FUNC_UNUSED, $urandom, 8'($urandom), 1'($urandom));
            end else begin
                fn = 2'($urandom_range(3));
                send_item(fn, $urandom, 8'($urandom), 1'($urandom));
                if (fn != FUNC_UNUSED) done++;
            end
        end
        items_random += done;
    endtask

    // ---------------------------------------------------------------------
    // receiver side: random m_tready, plus a long stall on request
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_seen != hold_orders) begin
            hold_seen <= hold_orders;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // result checker: oldest expectation against each accepted result item
    delay_result_t want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("result item with nothing awaited: status %0d", m_tuser);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[7:0] !== want.out_byte) begin
                    $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, m_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_tlast !== want.out_last) begin
                    $error("out_last: expected %0d, got %0d", want.out_last, m_tlast);
                    mismatch_count++;
                end
                if (m_tdata[15:8] !== want.out_length) begin
                    $error("out_length: expected %0d, got %0d", want.out_length,
                           m_tdata[15:8]);
                    mismatch_count++;
                end
                case (m_tuser)
                    STATUS_EMPTY:   not_ready_seen++;
                    STATUS_DROPPED: drops_seen++;
                    default:        if (m_tdata[15:8] != 0) bytes_out++;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    initial begin
        // release delay is 500 after reset for the whole directed table
        dir_rows = '{
            '{FUNC_POP,    32'h0000_0000, 8'h00, 1'b0, 1'b1, RES_EMPTY},   // empty after reset
            '{FUNC_PUSH,   32'hFFFF_FF00, 8'hFF, 1'b1, 1'b1, RES_OK_ZERO}, // release wraps to 0xF4
            '{FUNC_POP,    32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, RES_EMPTY},   // not yet, across wrap
            '{FUNC_POP,    32'h0000_00F4, 8'h00, 1'b0, 1'b1, RES_EMPTY},   // now == release
            '{FUNC_POP,    32'h0000_00F5, 8'h00, 1'b0, 1'b1,
              '{STATUS_OK, 8'hFF, 1'b1, 8'd1}},                            // one tick later
            '{FUNC_PUSH,   32'h0000_03E8, 8'h00, 1'b0, 1'b0, RES_OK_ZERO},
            '{FUNC_PUSH,   32'h0000_03E9, 8'hA5, 1'b0, 1'b0, RES_OK_ZERO},
            '{FUNC_PUSH,   32'h0000_03EA, 8'h5A, 1'b1, 1'b0, RES_OK_ZERO},
            '{FUNC_POP,    32'h0000_0640, 8'h00, 1'b0, 1'b0, RES_OK_ZERO},
            '{FUNC_POP,    32'h0000_0000, 8'h00, 1'b0, 1'b0, RES_OK_ZERO}, // mid-message, no time check
            '{FUNC_POP,    32'h0000_0000, 8'h00, 1'b0, 1'b0, RES_OK_ZERO},
            '{FUNC_POP,    32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, RES_EMPTY},
            '{FUNC_PUSH,   32'h0000_07D0, 8'h11, 1'b1, 1'b0, RES_OK_ZERO},
            '{FUNC_PUSH,   32'h0000_07D1, 8'h22, 1'b0, 1'b0, RES_OK_ZERO}, // left open
            '{FUNC_FLUSH,  32'h0000_0000, 8'h00, 1'b0, 1'b1, RES_OK_ZERO},
            '{FUNC_POP,    32'h7FFF_FFFF, 8'h00, 1'b0, 1'b1, RES_EMPTY},   // flushed
            '{FUNC_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, RES_OK_ZERO},
            '{FUNC_POP,    32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, RES_EMPTY},
            '{FUNC_PUSH,   32'h8000_0000, 8'h3C, 1'b1, 1'b0, RES_OK_ZERO},
            '{FUNC_POP,    32'h0000_0000, 8'h00, 1'b0, 1'b0, RES_OK_ZERO}, // half-range apart
            '{FUNC_PUSH,   32'h0000_1000, 8'hC3, 1'b0, 1'b0, RES_OK_ZERO},
            '{FUNC_POP,    32'h0000_1000, 8'h00, 1'b0, 1'b1, RES_EMPTY},   // open msg not visible
            '{FUNC_PUSH,   32'h0000_1001, 8'h7E, 1'b1, 1'b0, RES_OK_ZERO}
        };

        clear_queue_model();
        delay_ticks = DELAY_RESET;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // phase 1 back-pressure mix: sender idles 32%, receiver 84%
        src_idle_pct   = 32;
        sink_idle_pct <= 84;

        for (int i = 0; i < N_DIR; i++)
            send_item(dir_rows[i].fn, dir_rows[i].now, dir_rows[i].dbyte,
                      dir_rows[i].last_b, dir_rows[i].typed, dir_rows[i].res);

        // over-long message: 256th byte drops it, rest is swallowed
        tick = 32'h0001_0000;
        send_item(FUNC_FLUSH, tick, 8'h00, 1'b0);
        push_bytes(255, 1'b0);
        send_item(FUNC_PUSH, tick, 8'h99, 1'b0);
        push_bytes(3, 1'b1);
        // longest legal message, read back whole
        push_bytes(255, 1'b1);
        tick = tick + 32'd70000;
        pop_burst(256);

        // table full: 64 messages queued, next last byte is dropped
        send_item(FUNC_FLUSH, tick, 8'h00, 1'b0);
        for (int i = 0; i < MAX_MESSAGES; i++) push_bytes(1, 1'b1);
        push_bytes(1, 1'b1);
        push_bytes(2, 1'b1);
        tick = tick + 32'd70000;
        hold_orders <= hold_orders + 1;   // receiver stalls while pops keep coming
        pop_burst(MAX_MESSAGES + 2);
        send_item(FUNC_FLUSH, tick, 8'h00, 1'b0);

        // random phase A: zero delay, same back-pressure mix
        tick = $urandom;
        write_release_delay(16'd0);
        random_traffic(PHASE_ITEMS);

        // random phase B: longest delay, idling swapped
        write_release_delay(16'hFFFF);
        src_idle_pct   = 84;
        sink_idle_pct <= 32;
        random_traffic(PHASE_ITEMS);

        // random phase C: random delay, no idling but one long receiver stall
        write_release_delay(16'($urandom_range(1, 2000)));
        src_idle_pct   = 0;
        sink_idle_pct <= 0;
        hold_orders   <= hold_orders + 1;
        random_traffic(PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d items (%0d random): release edges, wrap-safe compare, flush,",
                 items_total, items_random);
        $display("  length/table drops, delays 500/0/65535/%0d; %0d bytes out, %0d drops.",
                 delay_ticks, bytes_out, drops_seen);
        if (mismatch_count == 0) begin
            $display("** timed_message_delay_fifo: PASSED **");
        end else begin
            $display("** timed_message_delay_fifo: FAILED **");
        end
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial begin
        #20_000_000;
        $display("timeout with %0d result items still awaited", awaited_results.size());
        $display("** timed_message_delay_fifo: FAILED **");
        $finish;
    end

endmodule

/* timed_message_delay_fifo.f */
rtl/core/tmdf_pkg.sv
rtl/core/tmdf_ctrl.sv
rtl/core/tmdf_dpath.sv
rtl/core/timed_message_delay_fifo.sv
dv/timed_message_delay_fifo_tb.sv
